@@ src/cfc_pkg.sv @@
// cfc_pkg: shared types, constants and codes for the control frame checker
// used by every module under control_frame_checker_unit; depends on nothing

package cfc_pkg;

    // frame geometry
    localparam int MAX_FRAME_BYTES = 4095;
    localparam int PORT_BCD_BYTES  = 3;
    localparam int LEN_W           = 13;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 20;

    localparam logic [LEN_W-1:0] LEN_SAT      = LEN_W'(MAX_FRAME_BYTES + 1);
    localparam logic [LEN_W-1:0] LEN_MAX      = LEN_W'(MAX_FRAME_BYTES);
    localparam logic [LEN_W-1:0] MIN_LEN      = LEN_W'(13);
    localparam logic [LEN_W-1:0] VERSION_LEN  = LEN_W'(18);
    localparam logic [LEN_W-1:0] WORK_LEN     = LEN_W'(224);
    localparam logic [LEN_W-1:0] TYPE_INDEX   = LEN_W'(10);
    localparam logic [LEN_W-1:0] BCD_START    = LEN_W'(12);
    localparam logic [LEN_W-1:0] BCD_END      = LEN_W'(12 + PORT_BCD_BYTES);

    // fixed type bytes
    localparam logic [7:0] TYPE_ACK     = 8'h30;
    localparam logic [7:0] TYPE_NACK    = 8'h40;
    localparam logic [7:0] TYPE_VERSION = 8'h10;
    localparam logic [7:0] TYPE_WORK    = 8'h20;

    localparam logic [19:0] PORT_MAXV = 20'h0FFFF;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_TYPE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LEN     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_LIMIT = 2'd2;

    // frame kinds
    localparam logic [2:0] KIND_UNKNOWN = 3'd0;
    localparam logic [2:0] KIND_ACK     = 3'd1;
    localparam logic [2:0] KIND_NACK    = 3'd2;
    localparam logic [2:0] KIND_VERSION = 3'd3;
    localparam logic [2:0] KIND_WORK    = 3'd4;
    localparam logic [2:0] KIND_PORT    = 3'd5;

    // port decode status
    localparam logic [2:0] PST_NONE      = 3'd0;
    localparam logic [2:0] PST_SHORT     = 3'd1;
    localparam logic [2:0] PST_BAD_BCD   = 3'd2;
    localparam logic [2:0] PST_OVER      = 3'd3;
    localparam logic [2:0] PST_ACCEPTED  = 3'd4;

    typedef struct packed {
        logic [7:0]  frame_type;
        logic [7:0]  min_len;
        logic [19:0] upper_limit;
    } cfg_t;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [7:0]       xor_acc;
        logic [7:0]       type_code;
        logic [19:0]      bcd_acc;
        logic             bcd_err;
    } frame_sum_t;

    typedef struct packed {
        logic             frame_ok;
        logic [2:0]       frame_kind;
        logic [LEN_W-1:0] frame_length;
        logic             report_len_match;
        logic [2:0]       port_status;
        logic [15:0]      port_value;
    } result_t;

endpackage

@@ src/cfc_cfg_regs.sv @@
// cfc_cfg_regs: configuration registers of the control frame checker
// depends on cfc_pkg

module cfc_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [cfc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cfc_pkg::CFG_DATA_W-1:0] cfg_data,
    output cfc_pkg::cfg_t                 cfg
);

    cfc_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_type  <= 8'd33;
            cfg_reg.min_len     <= 8'd16;
            cfg_reg.upper_limit <= 20'd65535;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                cfc_pkg::REG_FRAME_TYPE:  cfg_reg.frame_type  <= cfg_data[7:0];
                cfc_pkg::REG_MIN_LEN:     cfg_reg.min_len     <= cfg_data[7:0];
                cfc_pkg::REG_UPPER_LIMIT: cfg_reg.upper_limit <= cfg_data;
                default: ;  // index beyond the list is dropped
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ src/cfc_frame_accum.sv @@
// cfc_frame_accum: per-frame running state (count, xor, type byte, bcd port)
// depends on cfc_pkg; sum shows the state including the byte being stepped

module cfc_frame_accum (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    step,
    input  logic [7:0]              data_byte,
    input  logic                    last_byte,
    output cfc_pkg::frame_sum_t     sum
);

    cfc_pkg::frame_sum_t st_reg;
    cfc_pkg::frame_sum_t st_next;

    logic [3:0]  hi;
    logic [3:0]  lo;
    logic        in_bcd;
    logic [19:0] acc_x100;
    logic [19:0] digit_pair;

    assign hi = data_byte[7:4];
    assign lo = data_byte[3:0];
    assign in_bcd = (st_reg.len >= cfc_pkg::BCD_START) && (st_reg.len < cfc_pkg::BCD_END);
    // x100 as shifts and adds, kept modulo 2^20
    assign acc_x100 = (st_reg.bcd_acc << 6) + (st_reg.bcd_acc << 5) + (st_reg.bcd_acc << 2);
    assign digit_pair = {13'd0, hi, 3'd0} + {15'd0, hi, 1'b0} + {16'd0, lo};

    always_comb begin
        st_next = st_reg;
        if (st_reg.len >= cfc_pkg::TYPE_INDEX) begin
            st_next.xor_acc = st_reg.xor_acc ^ data_byte;
        end
        if (st_reg.len == cfc_pkg::TYPE_INDEX) begin
            st_next.type_code = data_byte;
        end
        if (in_bcd) begin
            if (hi > 4'd9 || lo > 4'd9) begin
                st_next.bcd_err = 1'b1;
            end else begin
                st_next.bcd_acc = acc_x100 + digit_pair;
            end
        end
        if (st_reg.len != cfc_pkg::LEN_SAT) begin
            st_next.len = st_reg.len + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '0;
        end else if (step) begin
            if (last_byte) begin
                st_reg <= '0;
            end else begin
                st_reg <= st_next;
            end
        end
    end

    assign sum = st_next;

endmodule

@@ src/cfc_verdict.sv @@
// cfc_verdict: frame verdict from the final running state and configuration
// depends on cfc_pkg; purely combinational

module cfc_verdict (
    input  cfc_pkg::frame_sum_t sum,
    input  cfc_pkg::cfg_t       cfg,
    output cfc_pkg::result_t    res
);

    logic       long_enough;
    logic       ok;
    logic [2:0] kind;
    logic       over;

    assign long_enough = sum.len >= cfc_pkg::MIN_LEN;
    assign ok = long_enough && (sum.len <= cfc_pkg::LEN_MAX) && (sum.xor_acc == 8'd0);
    assign over = (sum.bcd_acc > cfg.upper_limit) || (sum.bcd_acc > cfc_pkg::PORT_MAXV);

    // configured port type wins over the fixed codes
    always_comb begin
        kind = cfc_pkg::KIND_UNKNOWN;
        if (long_enough) begin
            if (sum.type_code == cfg.frame_type)              kind = cfc_pkg::KIND_PORT;
            else if (sum.type_code == cfc_pkg::TYPE_ACK)      kind = cfc_pkg::KIND_ACK;
            else if (sum.type_code == cfc_pkg::TYPE_NACK)     kind = cfc_pkg::KIND_NACK;
            else if (sum.type_code == cfc_pkg::TYPE_VERSION)  kind = cfc_pkg::KIND_VERSION;
            else if (sum.type_code == cfc_pkg::TYPE_WORK)     kind = cfc_pkg::KIND_WORK;
        end
    end

    always_comb begin
        res.frame_ok         = ok;
        res.frame_kind       = kind;
        res.frame_length     = sum.len;
        res.report_len_match =
            ((kind == cfc_pkg::KIND_VERSION) && (sum.len == cfc_pkg::VERSION_LEN)) ||
            ((kind == cfc_pkg::KIND_WORK) && (sum.len == cfc_pkg::WORK_LEN));
        res.port_status = cfc_pkg::PST_NONE;
        res.port_value  = 16'd0;
        if (ok && kind == cfc_pkg::KIND_PORT) begin
            if (sum.len < {5'd0, cfg.min_len}) begin
                res.port_status = cfc_pkg::PST_SHORT;
            end else if (sum.bcd_err) begin
                res.port_status = cfc_pkg::PST_BAD_BCD;
            end else if (over) begin
                res.port_status = cfc_pkg::PST_OVER;
            end else begin
                res.port_status = cfc_pkg::PST_ACCEPTED;
                res.port_value  = sum.bcd_acc[15:0];
            end
        end
    end

endmodule

@@ src/control_frame_checker_unit.sv @@
// control_frame_checker_unit: top level of the control frame checker
// depends on cfc_pkg, cfc_cfg_regs, cfc_frame_accum, cfc_verdict
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+-----------------------------------------
//   s_       | in        | s_valid / s_ready  | s_data_byte, s_last_byte
//   m_       | out       | m_valid / m_ready  | m_frame_ok .. m_port_value (one per frame)
//   cfg_     | in        | cfg_wr_en          | cfg_index, cfg_data
//
// one byte is taken per cycle while s_ready is high; a final byte waits in the
// input register, then the running-state update and verdict logic load the
// result register, which drives m_valid
// aresetn is synchronous and active low; it clears the running frame state,
// the handshake flags and loads the register defaults
// only a final byte needs a free result register; other bytes never stall, and a
// held result stalls the input side only when a final byte is waiting behind it

module control_frame_checker_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration
    input  logic                             cfg_wr_en,
    input  logic [cfc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cfc_pkg::CFG_DATA_W-1:0]   cfg_data,
    // byte input
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [7:0]                       s_data_byte,
    input  logic                             s_last_byte,
    // verdict output
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_frame_ok,
    output logic [2:0]                       m_frame_kind,
    output logic [cfc_pkg::LEN_W-1:0]        m_frame_length,
    output logic                             m_report_len_match,
    output logic [2:0]                       m_port_status,
    output logic [15:0]                      m_port_value
);

    cfc_pkg::cfg_t       cfg;
    cfc_pkg::frame_sum_t sum;
    cfc_pkg::result_t    res;

    // input register
    logic       in_vld_reg;
    logic [7:0] in_data_reg;
    logic       in_last_reg;

    // result register
    logic             out_vld_reg;
    cfc_pkg::result_t out_reg;

    logic advance;

    // a held byte moves on unless it is final and the result slot is still full
    assign advance = in_vld_reg && (!in_last_reg || !out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data_byte;
            in_last_reg <= s_last_byte;
        end
    end

    cfc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // running state advances once per byte and clears after a final byte
    cfc_frame_accum u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .data_byte (in_data_reg),
        .last_byte (in_last_reg),
        .sum       (sum)
    );

    cfc_verdict u_verdict (
        .sum (sum),
        .cfg (cfg),
        .res (res)
    );

    // result register: loaded on a final byte, emptied when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            out_reg <= res;
        end
    end

    assign m_valid            = out_vld_reg;
    assign m_frame_ok         = out_reg.frame_ok;
    assign m_frame_kind       = out_reg.frame_kind;
    assign m_frame_length     = out_reg.frame_length;
    assign m_report_len_match = out_reg.report_len_match;
    assign m_port_status      = out_reg.port_status;
    assign m_port_value       = out_reg.port_value;

endmodule

@@ tb/control_frame_checker_unit_tb.sv @@
// control_frame_checker_unit_tb: self-checking testbench for the control frame checker
// depends on cfc_pkg and control_frame_checker_unit; predicts verdicts in-house or uses typed-in ones
// and checks them field by field under random idling on both channels, except in the calm setting
`timescale 1ns / 100ps

module control_frame_checker_unit_tb;

    // stall watchdog, in cycles with no item moving on either channel
    localparam int STALL_LIMIT = 2000;
    // random byte budget for each register setting
    localparam int PHASE_BYTES = 80;
    localparam logic [cfc_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    // how the final byte of a generated frame treats the xor
    typedef enum logic [1:0] {CK_GOOD, CK_BAD, CK_RAND} ck_mode_t;

    typedef struct {
        int unsigned      len;
        logic [7:0]       type_byte;
        logic [23:0]      bcd;
        ck_mode_t         ck;
        bit               typed;
        cfc_pkg::result_t want;
    } frame_row_t;

    typedef struct {
        logic [19:0] frame_type;
        logic [19:0] min_len;
        logic [19:0] upper_limit;
        bit          calm;
    } setting_t;

    logic                           aclk;
    logic                           aresetn     = 1'b0;
    logic                           cfg_wr_en   = 1'b0;
    logic [cfc_pkg::CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [cfc_pkg::CFG_DATA_W-1:0] cfg_data    = '0;
    logic                           s_valid     = 1'b0;
    logic                           s_ready;
    logic [7:0]                     s_data_byte = '0;
    logic                           s_last_byte = 1'b0;
    logic                           m_valid;
    logic                           m_ready     = 1'b0;
    logic                           m_frame_ok;
    logic [2:0]                     m_frame_kind;
    logic [cfc_pkg::LEN_W-1:0]      m_frame_length;
    logic                           m_report_len_match;
    logic [2:0]                     m_port_status;
    logic [15:0]                    m_port_value;

    // register copy and running frame state of the predictor
    cfc_pkg::cfg_t cfg_m = '{frame_type: 8'd33, min_len: 8'd16, upper_limit: 20'd65535};
    logic [cfc_pkg::LEN_W-1:0] tr_count   = '0;
    logic [7:0]                tr_xor     = '0;
    logic [7:0]                tr_type    = '0;
    logic [19:0]               tr_bcd     = '0;
    logic                      tr_bcd_err = 1'b0;

    // verdicts still owed by the block, oldest first
    cfc_pkg::result_t verdict_q [$];
    // a typed-in verdict that replaces the predicted one for the current frame
    bit               pin_on = 1'b0;
    cfc_pkg::result_t pin_val;

    bit calm = 1'b0;
    int fail_cnt = 0;
    int idle_cycles = 0;

    control_frame_checker_unit u_top (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_data_byte        (s_data_byte),
        .s_last_byte        (s_last_byte),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_frame_ok         (m_frame_ok),
        .m_frame_kind       (m_frame_kind),
        .m_frame_length     (m_frame_length),
        .m_report_len_match (m_report_len_match),
        .m_port_status      (m_port_status),
        .m_port_value       (m_port_value)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // directed frames, all at the reset register values (port type 33, min 16, limit 65535)
    frame_row_t dir_rows [21] = '{
        // shortest valid frame, plain ack
        '{13, cfc_pkg::TYPE_ACK, 24'h0, CK_GOOD, 1,
          '{1'b1, cfc_pkg::KIND_ACK, 13'd13, 1'b0, cfc_pkg::PST_NONE, 16'd0}},
        // one byte under the least length
        '{12, cfc_pkg::TYPE_ACK, 24'h0, CK_GOOD, 1,
          '{1'b0, cfc_pkg::KIND_UNKNOWN, 13'd12, 1'b0, cfc_pkg::PST_NONE, 16'd0}},
        '{1, cfc_pkg::TYPE_ACK, 24'h0, CK_GOOD, 1,
          '{1'b0, cfc_pkg::KIND_UNKNOWN, 13'd1, 1'b0, cfc_pkg::PST_NONE, 16'd0}},
        // type byte is the final byte
        '{11, cfc_pkg::TYPE_ACK, 24'h0, CK_GOOD, 0, '{default: '0}},
        // kind is reported even with a broken checksum
        '{13, cfc_pkg::TYPE_NACK, 24'h0, CK_BAD, 1,
          '{1'b0, cfc_pkg::KIND_NACK, 13'd13, 1'b0, cfc_pkg::PST_NONE, 16'd0}},
        '{18, cfc_pkg::TYPE_VERSION, 24'h0, CK_GOOD, 1,
          '{1'b1, cfc_pkg::KIND_VERSION, 13'd18, 1'b1, cfc_pkg::PST_NONE, 16'd0}},
        '{19, cfc_pkg::TYPE_VERSION, 24'h0, CK_GOOD, 1,
          '{1'b1, cfc_pkg::KIND_VERSION, 13'd19, 1'b0, cfc_pkg::PST_NONE, 16'd0}},
        '{18, cfc_pkg::TYPE_VERSION, 24'h0, CK_BAD, 1,
          '{1'b0, cfc_pkg::KIND_VERSION, 13'd18, 1'b1, cfc_pkg::PST_NONE, 16'd0}},
        '{224, cfc_pkg::TYPE_WORK, 24'h0, CK_GOOD, 1,
          '{1'b1, cfc_pkg::KIND_WORK, 13'd224, 1'b1, cfc_pkg::PST_NONE, 16'd0}},
        // port decode: top of the 16-bit range, one past it, zero, largest six-digit value
        '{20, 8'd33, 24'h065535, CK_GOOD, 1,
          '{1'b1, cfc_pkg::KIND_PORT, 13'd20, 1'b0, cfc_pkg::PST_ACCEPTED, 16'd65535}},
        '{20, 8'd33, 24'h065536, CK_GOOD, 1,
          '{1'b1, cfc_pkg::KIND_PORT, 13'd20, 1'b0, cfc_pkg::PST_OVER, 16'd0}},
        '{16, 8'd33, 24'h000000, CK_GOOD, 1,
          '{1'b1, cfc_pkg::KIND_PORT, 13'd16, 1'b0, cfc_pkg::PST_ACCEPTED, 16'd0}},
        '{20, 8'd33, 24'h999999, CK_GOOD, 1,
          '{1'b1, cfc_pkg::KIND_PORT, 13'd20, 1'b0, cfc_pkg::PST_OVER, 16'd0}},
        // port frame under the least port length
        '{15, 8'd33, 24'h000001, CK_GOOD, 1,
          '{1'b1, cfc_pkg::KIND_PORT, 13'd15, 1'b0, cfc_pkg::PST_SHORT, 16'd0}},
        // bad low nibbles, in the first and the last bcd byte
        '{20, 8'd33, 24'h0A0000, CK_GOOD, 1,
          '{1'b1, cfc_pkg::KIND_PORT, 13'd20, 1'b0, cfc_pkg::PST_BAD_BCD, 16'd0}},
        '{20, 8'd33, 24'h00000F, CK_GOOD, 1,
          '{1'b1, cfc_pkg::KIND_PORT, 13'd20, 1'b0, cfc_pkg::PST_BAD_BCD, 16'd0}},
        // port frame with a broken checksum gives no decode
        '{20, 8'd33, 24'h065535, CK_BAD, 1,
          '{1'b0, cfc_pkg::KIND_PORT, 13'd20, 1'b0, cfc_pkg::PST_NONE, 16'd0}},
        // predicted port frames, two of them ending inside the bcd field, then an unknown type
        '{13, 8'd33, 24'h123456, CK_GOOD, 0, '{default: '0}},
        '{14, 8'd33, 24'h123456, CK_GOOD, 0, '{default: '0}},
        '{20, 8'd33, 24'h012345, CK_GOOD, 0, '{default: '0}},
        '{22, 8'h00, 24'h0, CK_GOOD, 1,
          '{1'b1, cfc_pkg::KIND_UNKNOWN, 13'd22, 1'b0, cfc_pkg::PST_NONE, 16'd0}}
    };

    // register settings walked by the random part; the fourth is drawn at run time
    setting_t settings [5] = '{
        // frame type register written with upper junk to check masking
        '{20'hFFFFF, 20'h0000F, 20'd999999, 1'b0},
        // port type equal to ack (priority), longest port minimum, zero limit, no idling
        '{20'h00030, 20'hABCFF, 20'd0, 1'b1},
        '{20'h00000, 20'd16, 20'd65536, 1'b0},
        '{20'd0, 20'd0, 20'd0, 1'b0},
        '{20'd33, 20'd16, 20'd65535, 1'b0}
    };

    // predictor: fold one accepted byte into the frame state, owe a verdict on the last one
    task automatic fold_frame_byte(input logic [7:0] b, input logic last);
        int unsigned      idx;
        logic [3:0]       hi;
        logic [3:0]       lo;
        cfc_pkg::result_t v;
        idx = 32'(tr_count);
        hi  = b[7:4];
        lo  = b[3:0];
        if (idx >= cfc_pkg::TYPE_INDEX) tr_xor ^= b;
        if (idx == cfc_pkg::TYPE_INDEX) tr_type = b;
        if (idx >= cfc_pkg::BCD_START && idx < cfc_pkg::BCD_END) begin
            // any nibble above nine is sticky for the rest of the frame
            if (hi > 4'd9 || lo > 4'd9) tr_bcd_err = 1'b1;
            else tr_bcd = 20'((tr_bcd * 100) + hi * 10 + lo);
        end
        if (tr_count < cfc_pkg::LEN_SAT) tr_count++;
        if (last) begin
            v = '0;
            v.frame_length = tr_count;
            v.frame_ok = tr_count >= cfc_pkg::MIN_LEN && tr_count <= cfc_pkg::LEN_MAX
                         && tr_xor == 8'd0;
            if (tr_count >= cfc_pkg::MIN_LEN) begin
                // the programmable port type wins over the fixed codes
                if (tr_type == cfg_m.frame_type) v.frame_kind = cfc_pkg::KIND_PORT;
                else if (tr_type == cfc_pkg::TYPE_ACK) v.frame_kind = cfc_pkg::KIND_ACK;
                else if (tr_type == cfc_pkg::TYPE_NACK) v.frame_kind = cfc_pkg::KIND_NACK;
                else if (tr_type == cfc_pkg::TYPE_VERSION)
                    v.frame_kind = cfc_pkg::KIND_VERSION;
                else if (tr_type == cfc_pkg::TYPE_WORK) v.frame_kind = cfc_pkg::KIND_WORK;
            end
            v.report_len_match =
                (v.frame_kind == cfc_pkg::KIND_VERSION && tr_count == cfc_pkg::VERSION_LEN)
                || (v.frame_kind == cfc_pkg::KIND_WORK && tr_count == cfc_pkg::WORK_LEN);
            if (v.frame_ok && v.frame_kind == cfc_pkg::KIND_PORT) begin
                if (tr_count < cfg_m.min_len) v.port_status = cfc_pkg::PST_SHORT;
                else if (tr_bcd_err) v.port_status = cfc_pkg::PST_BAD_BCD;
                else if (tr_bcd > cfg_m.upper_limit || tr_bcd > cfc_pkg::PORT_MAXV)
                    v.port_status = cfc_pkg::PST_OVER;
                else begin
                    v.port_status = cfc_pkg::PST_ACCEPTED;
                    v.port_value  = tr_bcd[15:0];
                end
            end
            verdict_q.push_back(pin_on ? pin_val : v);
            pin_on     = 1'b0;
            tr_count   = '0;
            tr_xor     = '0;
            tr_type    = '0;
            tr_bcd     = '0;
            tr_bcd_err = 1'b0;
        end
    endtask

    // offer one byte; called and returns at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic last);
        while (!calm && $urandom_range(0, 99) < 28) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        s_last_byte <= last;
        do @(posedge aclk); while (s_ready !== 1'b1);
        fold_frame_byte(b, last);
        @(negedge aclk);
    endtask

    // build a frame around a type byte and bcd field, then fix, break or leave the checksum
    task automatic send_frame(input int unsigned len, input logic [7:0] type_byte,
                              input logic [23:0] bcd, input ck_mode_t ck);
        logic [7:0] fb [$];
        logic [7:0] chk;
        chk = '0;
        for (int unsigned i = 0; i < len; i++) begin
            if (i == cfc_pkg::TYPE_INDEX) fb.push_back(type_byte);
            else if (i >= cfc_pkg::BCD_START && i < cfc_pkg::BCD_END)
                fb.push_back(bcd[8 * (14 - i) +: 8]);
            else fb.push_back(8'($urandom));
        end
        if (len >= 12) begin
            for (int unsigned i = 32'(cfc_pkg::TYPE_INDEX); i < len - 1; i++) chk ^= fb[i];
            case (ck)
                CK_GOOD: fb[len - 1] = chk;
                CK_BAD:  fb[len - 1] = chk ^ 8'($urandom_range(1, 255));
                default: ;
            endcase
        end
        foreach (fb[i]) send_byte(fb[i], i == fb.size() - 1);
    endtask

    // one register write, the predictor copy follows at the same edge
    task automatic write_reg(input logic [cfc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cfc_pkg::CFG_DATA_W-1:0] d);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge aclk);
        case (idx)
            cfc_pkg::REG_FRAME_TYPE:  cfg_m.frame_type  = d[7:0];
            cfc_pkg::REG_MIN_LEN:     cfg_m.min_len     = d[7:0];
            cfc_pkg::REG_UPPER_LIMIT: cfg_m.upper_limit = d;
            default: ;
        endcase
        @(negedge aclk);
    endtask

    // wait until every owed verdict is out, plus the pipeline depth
    task automatic drain();
        s_valid <= 1'b0;
        while (verdict_q.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    function automatic logic [23:0] to_bcd(input int unsigned v);
        logic [23:0] r;
        for (int i = 0; i < 6; i++) begin
            r[i * 4 +: 4] = 4'(v % 10);
            v = v / 10;
        end
        return r;
    endfunction

    task automatic note_fail(input string what, input cfc_pkg::result_t want,
                             input cfc_pkg::result_t got);
        fail_cnt++;
        if (fail_cnt <= 10) begin
            $write("%s: want ok=%0d kind=%0d len=%0d match=%0d status=%0d value=%0d",
                   what, want.frame_ok, want.frame_kind, want.frame_length,
                   want.report_len_match, want.port_status, want.port_value);
            $display(", got ok=%0d kind=%0d len=%0d match=%0d status=%0d value=%0d",
                     got.frame_ok, got.frame_kind, got.frame_length,
                     got.report_len_match, got.port_status, got.port_value);
        end
    endtask

    // result side: random back-pressure, none while calm
    always @(negedge aclk) begin
        m_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 28);
    end

    // verdict check against the oldest owed verdict
    always @(posedge aclk) begin
        cfc_pkg::result_t got;
        cfc_pkg::result_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            got = '{m_frame_ok, m_frame_kind, m_frame_length, m_report_len_match,
                    m_port_status, m_port_value};
            if (verdict_q.size() == 0) begin
                note_fail("verdict with none owed", '0, got);
            end else begin
                want = verdict_q.pop_front();
                if (got.frame_ok !== want.frame_ok || got.frame_kind !== want.frame_kind
                    || got.frame_length !== want.frame_length
                    || got.report_len_match !== want.report_len_match
                    || got.port_status !== want.port_status
                    || got.port_value !== want.port_value)
                    note_fail("verdict mismatch", want, got);
            end
        end
    end

    // stall watchdog
    always @(posedge aclk) begin
        if ((s_valid && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL control_frame_checker_unit");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int unsigned flen;
        int unsigned pv;
        int unsigned ph_bytes;
        int          lim;
        logic [7:0]  ftype;
        logic [23:0] fbcd;
        ck_mode_t    fck;

        // fourth setting: random values, upper junk on the 8-bit registers
        settings[3].frame_type  = 20'($urandom);
        settings[3].min_len     = 20'($urandom_range(15, 255)) | (20'($urandom) & 20'hFFF00);
        settings[3].upper_limit = 20'($urandom_range(0, 999999));

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed frames at the reset register values
        foreach (dir_rows[r]) begin
            pin_on  = dir_rows[r].typed;
            pin_val = dir_rows[r].want;
            send_frame(dir_rows[r].len, dir_rows[r].type_byte, dir_rows[r].bcd, dir_rows[r].ck);
        end

        foreach (settings[p]) begin
            drain();
            write_reg(cfc_pkg::REG_FRAME_TYPE, settings[p].frame_type);
            write_reg(cfc_pkg::REG_MIN_LEN, settings[p].min_len);
            write_reg(cfc_pkg::REG_UPPER_LIMIT, settings[p].upper_limit);
            // index past the register list must be ignored
            write_reg(REG_SPARE, 20'($urandom));
            cfg_wr_en <= 1'b0;
            calm = settings[p].calm;
            ph_bytes = 0;
            while (ph_bytes < PHASE_BYTES) begin
                case ($urandom_range(0, 19)) inside
                    // port frame, value random, small, near the limit or at the 16-bit edge; checksum mostly good
                    [0:10]: begin
                        case ($urandom_range(0, 3))
                            0: pv = $urandom_range(0, 999999);
                            1: begin
                                lim = int'(cfg_m.upper_limit) + int'($urandom_range(0, 4)) - 2;
                                pv = lim < 0 ? 0 : (lim > 999999 ? 999999 : lim);
                            end
                            2: pv = 65535 + $urandom_range(0, 1);
                            default: pv = $urandom_range(0, 99);
                        endcase
                        flen  = (cfg_m.min_len < 15 ? 15 : 32'(cfg_m.min_len))
                                + $urandom_range(0, 6);
                        ftype = cfg_m.frame_type;
                        fbcd  = to_bcd(pv);
                        fck   = ($urandom_range(0, 9) == 0) ? CK_BAD : CK_GOOD;
                    end
                    // fixed-code report frames
                    [11:14]: begin
                        case ($urandom_range(0, 3))
                            0: ftype = cfc_pkg::TYPE_ACK;
                            1: ftype = cfc_pkg::TYPE_NACK;
                            2: ftype = cfc_pkg::TYPE_VERSION;
                            default: ftype = cfc_pkg::TYPE_WORK;
                        endcase
                        flen = $urandom_range(13, 30);
                        if (ftype == cfc_pkg::TYPE_VERSION && $urandom_range(0, 1))
                            flen = 32'(cfc_pkg::VERSION_LEN);
                        if (ftype == cfc_pkg::TYPE_WORK && $urandom_range(0, 9) == 0)
                            flen = 32'(cfc_pkg::WORK_LEN);
                        fbcd = 24'($urandom);
                        fck  = ($urandom_range(0, 4) == 0) ? CK_BAD : CK_GOOD;
                    end
                    // port frames of any length up to just past the minimum, random digits, any checksum
                    [15:16]: begin
                        flen  = $urandom_range(1, int'(cfg_m.min_len) + 3);
                        ftype = cfg_m.frame_type;
                        fbcd  = 24'($urandom);
                        fck   = ck_mode_t'($urandom_range(0, 2));
                    end
                    // noise
                    default: begin
                        flen  = $urandom_range(1, 30);
                        ftype = 8'($urandom);
                        fbcd  = 24'($urandom);
                        fck   = ck_mode_t'($urandom_range(0, 2));
                    end
                endcase
                send_frame(flen, ftype, fbcd, fck);
                ph_bytes += flen;
            end
            calm = 1'b0;
        end

        drain();
        repeat (10) @(negedge aclk);
        if (fail_cnt == 0) begin
            $display("PASS control_frame_checker_unit");
        end else begin
            $display("FAIL control_frame_checker_unit");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/cfc_pkg.sv
src/cfc_cfg_regs.sv
src/cfc_frame_accum.sv
src/cfc_verdict.sv
src/control_frame_checker_unit.sv
tb/control_frame_checker_unit_tb.sv
